// File: hdl/tli_pkg.sv
// Shared types and constants for the table linear interpolator.
// No dependencies; used by tli_divider, table_linear_interpolator_core, interp_check and testbench.
`default_nettype none

package tli_pkg;

  // item command codes
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  // quotient bits kept; larger quotients saturate to 2^40
  localparam int QUO_W  = 41;
  localparam int HI_W   = PROD_W - QUO_W;
  localparam logic [QUO_W-1:0] SAT_Q = {1'b1, {(QUO_W-1){1'b0}}};

  // how a query resolves once the table ends are known
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_FIRST,
    KIND_LAST,
    KIND_INTERP
  } kind_t;

  // sideband that travels with a division
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic              neg;
  } side_t;

endpackage

`default_nettype wire

// File: hdl/table_linear_interpolator_core.sv
// Piecewise linear interpolator over a breakpoint table; uses tli_pkg, tli_ram
// and tli_divider.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds in place while a result waits on out_ready.
// Reset (rst_n, synchronous): clears valid bits and table_size; table contents
// stay undefined until loaded.
`default_nettype none

module table_linear_interpolator_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_entry_x,
  input  logic signed [31:0] in_entry_y,
  input  logic signed [31:0] in_query_x,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_y
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = AW + 1;
  // binary search levels; never fewer than the iterations n-1 entries need
  localparam int LVL = AW;
  localparam int DW  = tli_pkg::DATA_W;
  localparam int QW  = tli_pkg::QUO_W;

  // ---------------------------------------------------------------------
  // Configuration and global advance
  // ---------------------------------------------------------------------
  logic [6:0]    cfg_table_size_r;
  logic [NW-1:0] ncl;      // table size clipped to the depth
  logic [AW-1:0] nm1;      // index of the last entry
  logic          adv;
  logic          in_acc;
  logic          in_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_table_size_r <= '0;
    end else if (cfg_we) begin
      cfg_table_size_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (int'(cfg_table_size_r) > TABLE_DEPTH) begin
      ncl = NW'(TABLE_DEPTH);
    end else begin
      ncl = NW'(cfg_table_size_r);
    end
  end

  assign nm1 = AW'(ncl - NW'(1));

  // every stage moves when the output register is free or being drained
  logic out_valid_r;
  logic [DW-1:0] out_result_y_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && in_ready;
  assign in_ok    = 32'(in_entry_index) < TABLE_DEPTH;

  // ---------------------------------------------------------------------
  // Search pipeline. Each stage owns its own copy of the table: a load item
  // writes a copy as it passes the stage that reads it, so every query sees
  // exactly the loads accepted ahead of it.
  // ---------------------------------------------------------------------
  logic          sv_r    [0:LVL];
  logic          scmd_r  [0:LVL];
  logic          sok_r   [0:LVL];
  logic [5:0]    sidx_r  [0:LVL];
  logic [DW-1:0] skey_r  [0:LVL];  // entry_x for loads, query_x for queries
  logic [DW-1:0] sdat_r  [0:LVL];  // entry_y
  logic [AW-1:0] sl_r    [0:LVL];
  logic [AW-1:0] sr_r    [0:LVL];
  logic [AW-1:0] smid_r  [1:LVL];
  logic          spend_r [1:LVL];  // compare against this stage's read data
  tli_pkg::kind_t sk_r   [1:LVL];
  logic [DW-1:0] sclamp_r[1:LVL];

  logic [DW-1:0] srch_rd [0:LVL-1];
  logic [AW-1:0] rl      [0:LVL];  // left/right after this stage's compare
  logic [AW-1:0] rr      [0:LVL];
  logic [AW-1:0] mid     [0:LVL-1];
  logic          act     [0:LVL-1];

  // end points: first and last entries, read as the item is accepted
  logic [DW-1:0] ep_xf, ep_yf, ep_xl, ep_yl;
  logic          ep_we;
  assign ep_we = in_acc && (in_command == tli_pkg::CMD_LOAD) && in_ok;

  tli_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_ep_xf (
    .clk, .we(ep_we), .waddr(AW'(in_entry_index)), .wdata(in_entry_x),
    .re(adv), .raddr('0), .rdata(ep_xf));
  tli_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_ep_yf (
    .clk, .we(ep_we), .waddr(AW'(in_entry_index)), .wdata(in_entry_y),
    .re(adv), .raddr('0), .rdata(ep_yf));
  tli_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_ep_xl (
    .clk, .we(ep_we), .waddr(AW'(in_entry_index)), .wdata(in_entry_x),
    .re(adv), .raddr(nm1), .rdata(ep_xl));
  tli_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_ep_yl (
    .clk, .we(ep_we), .waddr(AW'(in_entry_index)), .wdata(in_entry_y),
    .re(adv), .raddr(nm1), .rdata(ep_yl));

  // classify the query against the table ends (stage 0)
  tli_pkg::kind_t kind0;
  logic [DW-1:0]  clamp0;
  always_comb begin
    kind0  = tli_pkg::KIND_INTERP;
    clamp0 = ep_yf;
    if (ncl == '0) begin
      kind0  = tli_pkg::KIND_ZERO;
      clamp0 = '0;
    end else if (ncl == NW'(1) || $signed(skey_r[0]) <= $signed(ep_xf)) begin
      kind0  = tli_pkg::KIND_FIRST;
      clamp0 = ep_yf;
    end else if ($signed(skey_r[0]) >= $signed(ep_xl)) begin
      kind0  = tli_pkg::KIND_LAST;
      clamp0 = ep_yl;
    end
  end

  // resolve the previous level's compare; x < x[mid] moves right down
  for (genvar j = 0; j <= LVL; j++) begin : g_res
    if (j == 0) begin : g_first
      assign rl[0] = sl_r[0];
      assign rr[0] = sr_r[0];
    end else begin : g_cmp
      logic go_left;
      assign go_left = $signed(skey_r[j]) < $signed(srch_rd[j-1]);
      assign rl[j] = (spend_r[j] && !go_left) ? smid_r[j] : sl_r[j];
      assign rr[j] = (spend_r[j] && go_left)  ? smid_r[j] : sr_r[j];
    end
  end

  for (genvar j = 0; j < LVL; j++) begin : g_lvl
    logic st_we;
    assign act[j] = AW'(rr[j] - rl[j]) > AW'(1);
    assign mid[j] = AW'(({1'b0, rl[j]} + {1'b0, rr[j]}) >> 1);
    assign st_we  = adv && sv_r[j] && (scmd_r[j] == tli_pkg::CMD_LOAD) && sok_r[j];
    tli_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_srch (
      .clk, .we(st_we), .waddr(AW'(sidx_r[j])), .wdata(skey_r[j]),
      .re(adv), .raddr(mid[j]), .rdata(srch_rd[j]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= LVL; j++) begin
        sv_r[j] <= 1'b0;
      end
    end else if (adv) begin
      sv_r[0] <= in_valid;
      for (int j = 1; j <= LVL; j++) begin
        sv_r[j] <= sv_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scmd_r[0] <= in_command;
      sok_r[0]  <= in_ok;
      sidx_r[0] <= in_entry_index;
      skey_r[0] <= (in_command == tli_pkg::CMD_LOAD) ? in_entry_x : in_query_x;
      sdat_r[0] <= in_entry_y;
      sl_r[0]   <= '0;
      sr_r[0]   <= nm1;
      sk_r[1]     <= kind0;
      sclamp_r[1] <= clamp0;
      for (int j = 2; j <= LVL; j++) begin
        sk_r[j]     <= sk_r[j-1];
        sclamp_r[j] <= sclamp_r[j-1];
      end
      for (int j = 0; j < LVL; j++) begin
        scmd_r[j+1]  <= scmd_r[j];
        sok_r[j+1]   <= sok_r[j];
        sidx_r[j+1]  <= sidx_r[j];
        skey_r[j+1]  <= skey_r[j];
        sdat_r[j+1]  <= sdat_r[j];
        sl_r[j+1]    <= rl[j];
        sr_r[j+1]    <= rr[j];
        smid_r[j+1]  <= mid[j];
        spend_r[j+1] <= act[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Segment fetch: x/y at left and left+1
  // ---------------------------------------------------------------------
  logic          f_we_x, f_we_y;
  logic [AW-1:0] fa0, fa1;
  logic [DW-1:0] fx0_rd, fx1_rd, fy0_rd, fy1_rd;

  assign f_we_x = adv && sv_r[LVL] && (scmd_r[LVL] == tli_pkg::CMD_LOAD) && sok_r[LVL];
  assign f_we_y = f_we_x;
  assign fa0    = rl[LVL];
  assign fa1    = AW'({1'b0, rl[LVL]} + NW'(1));

  tli_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_fx0 (
    .clk, .we(f_we_x), .waddr(AW'(sidx_r[LVL])), .wdata(skey_r[LVL]),
    .re(adv), .raddr(fa0), .rdata(fx0_rd));
  tli_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_fx1 (
    .clk, .we(f_we_x), .waddr(AW'(sidx_r[LVL])), .wdata(skey_r[LVL]),
    .re(adv), .raddr(fa1), .rdata(fx1_rd));
  tli_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_fy0 (
    .clk, .we(f_we_y), .waddr(AW'(sidx_r[LVL])), .wdata(sdat_r[LVL]),
    .re(adv), .raddr(fa0), .rdata(fy0_rd));
  tli_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_fy1 (
    .clk, .we(f_we_y), .waddr(AW'(sidx_r[LVL])), .wdata(sdat_r[LVL]),
    .re(adv), .raddr(fa1), .rdata(fy1_rd));

  // loads drop out here: only queries keep a valid bit
  logic           sf_v_r;
  logic [DW-1:0]  sf_key_r;
  tli_pkg::kind_t sf_kind_r;
  logic [DW-1:0]  sf_clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_v_r <= 1'b0;
    end else if (adv) begin
      sf_v_r <= sv_r[LVL] && (scmd_r[LVL] == tli_pkg::CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sf_key_r   <= skey_r[LVL];
      sf_kind_r  <= sk_r[LVL];
      sf_clamp_r <= sclamp_r[LVL];
    end
  end

  // ---------------------------------------------------------------------
  // Differences. Clamped results and equal breakpoints go through the
  // arithmetic with a zero product, so the divider returns zero.
  // ---------------------------------------------------------------------
  logic               div_go;
  logic signed [DW:0] dx_nxt, dy_nxt, dn_nxt;
  logic [DW-1:0]      base_nxt;

  always_comb begin
    div_go   = (sf_kind_r == tli_pkg::KIND_INTERP) && (fx0_rd != fx1_rd);
    base_nxt = (sf_kind_r == tli_pkg::KIND_INTERP) ? fy0_rd : sf_clamp_r;
    dx_nxt   = '0;
    dy_nxt   = '0;
    dn_nxt   = (DW+1)'(1);
    if (div_go) begin
      dx_nxt = $signed({sf_key_r[DW-1], sf_key_r}) - $signed({fx0_rd[DW-1], fx0_rd});
      dy_nxt = $signed({fy1_rd[DW-1], fy1_rd}) - $signed({fy0_rd[DW-1], fy0_rd});
      dn_nxt = $signed({fx1_rd[DW-1], fx1_rd}) - $signed({fx0_rd[DW-1], fx0_rd});
    end
  end

  logic               d_v_r;
  logic signed [DW:0] dx_r, dy_r, dn_r;
  logic [DW-1:0]      d_base_r;

  // magnitudes and result sign
  logic [DW:0]   ax_full, ay_full, ad_full;
  logic          m1_v_r;
  logic [DW-1:0] ax_r, ay_r, ad_r, m1_base_r;
  logic          m1_neg_r;

  assign ax_full = dx_r[DW] ? (DW+1)'(-dx_r) : dx_r;
  assign ay_full = dy_r[DW] ? (DW+1)'(-dy_r) : dy_r;
  assign ad_full = dn_r[DW] ? (DW+1)'(-dn_r) : dn_r;

  // product
  logic                       m2_v_r;
  logic [tli_pkg::PROD_W-1:0] prod_nxt, prod_r;
  logic [DW-1:0]              m2_d_r;
  tli_pkg::side_t             m2_side_r;

  assign prod_nxt = ax_r * ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r  <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r  <= sf_v_r;
      m1_v_r <= d_v_r;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      dn_r      <= dn_nxt;
      d_base_r  <= base_nxt;
      ax_r      <= ax_full[DW-1:0];
      ay_r      <= ay_full[DW-1:0];
      ad_r      <= ad_full[DW-1:0];
      m1_neg_r  <= dx_r[DW] ^ dy_r[DW] ^ dn_r[DW];
      m1_base_r <= d_base_r;
      prod_r    <= prod_nxt;
      m2_d_r    <= ad_r;
      m2_side_r <= '{base: m1_base_r, neg: m1_neg_r};
    end
  end

  // ---------------------------------------------------------------------
  // Division, one quotient bit per stage
  // ---------------------------------------------------------------------
  logic           div_v;
  logic [QW-1:0]  div_q;
  tli_pkg::side_t div_side;

  tli_divider u_div (
    .clk,
    .rst_n,
    .en          (adv),
    .in_valid    (m2_v_r),
    .in_dividend (prod_r),
    .in_divisor  (m2_d_r),
    .in_side     (m2_side_r),
    .out_valid   (div_v),
    .out_quot    (div_q),
    .out_side    (div_side)
  );

  // ---------------------------------------------------------------------
  // Final add, saturate to 32 bits, output register
  // ---------------------------------------------------------------------
  logic signed [QW:0] sum;
  logic [DW-1:0]      res_nxt;

  always_comb begin
    if (div_side.neg) begin
      sum = $signed({{(QW+1-DW){div_side.base[DW-1]}}, div_side.base})
            - $signed({1'b0, div_q});
    end else begin
      sum = $signed({{(QW+1-DW){div_side.base[DW-1]}}, div_side.base})
            + $signed({1'b0, div_q});
    end
    if (sum[QW:DW-1] != {(QW+2-DW){sum[QW]}}) begin
      res_nxt = sum[QW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      res_nxt = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_y_r <= res_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_result_y = out_result_y_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_quot_sat: assert property (@(posedge clk) disable iff (!rst_n)
    div_v |-> (div_q <= tli_pkg::SAT_Q))
    else $error("quotient above saturation limit");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(sf_v_r) && $stable(div_v) && $stable(m2_v_r)))
    else $error("pipeline moved during stall");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && sv_r[LVL] && (scmd_r[LVL] == tli_pkg::CMD_LOAD)) |=> !sf_v_r)
    else $error("load item produced a result");

endmodule

`default_nettype wire

// File: hdl/tli_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/tli_divider.sv
// Pipelined restoring divider: 64-bit dividend by 32-bit divisor, one
// quotient bit per stage, quotient saturated to 2^40. Uses tli_pkg.
`default_nettype none

module tli_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [tli_pkg::PROD_W-1:0]   in_dividend,
  input  logic [tli_pkg::DATA_W-1:0]   in_divisor,
  input  tli_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [tli_pkg::QUO_W-1:0]    out_quot,
  output tli_pkg::side_t               out_side
);

  localparam int QW = tli_pkg::QUO_W;
  localparam int DW = tli_pkg::DATA_W;

  logic          v_r    [0:QW];
  logic          ov_r   [0:QW];
  logic [DW-1:0] rem_r  [0:QW];
  logic [QW-1:0] low_r  [0:QW];
  logic [QW-1:0] q_r    [0:QW];
  logic [DW-1:0] d_r    [0:QW];
  tli_pkg::side_t side_r [0:QW];

  logic [DW-1:0] rem_nxt [1:QW];
  logic          qb_nxt  [1:QW];
  logic [DW-1:0] hi_ext;

  // quotient >= 2^41 exactly when the top dividend bits reach the divisor
  assign hi_ext = DW'(in_dividend[tli_pkg::PROD_W-1:QW]);

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [DW:0] t;
    assign t          = {rem_r[i-1], low_r[i-1][QW-1]};
    assign qb_nxt[i]  = t >= {1'b0, d_r[i-1]};
    assign rem_nxt[i] = qb_nxt[i] ? DW'(t - {1'b0, d_r[i-1]}) : t[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QW; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= QW; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ov_r[0]   <= hi_ext >= in_divisor;
      rem_r[0]  <= (hi_ext >= in_divisor) ? '0 : hi_ext;
      low_r[0]  <= in_dividend[QW-1:0];
      q_r[0]    <= '0;
      d_r[0]    <= in_divisor;
      side_r[0] <= in_side;
      for (int i = 1; i <= QW; i++) begin
        ov_r[i]   <= ov_r[i-1];
        rem_r[i]  <= rem_nxt[i];
        low_r[i]  <= {low_r[i-1][QW-2:0], 1'b0};
        q_r[i]    <= {q_r[i-1][QW-2:0], qb_nxt[i]};
        d_r[i]    <= d_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_side  = side_r[QW];
  assign out_quot  = (ov_r[QW] || (q_r[QW][QW-1] && (|q_r[QW][QW-2:0])))
                     ? tli_pkg::SAT_Q : q_r[QW];

endmodule

`default_nettype wire

// File: test/interp_check.sv
// Watches the interpolator's channels, predicts each query result from its own
// copy of the breakpoint table and compares in order. Depends on tli_pkg.
`timescale 1ns / 100ps

module interp_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_command,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_entry_x,
  input  logic signed [31:0] in_entry_y,
  input  logic signed [31:0] in_query_x,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_result_y,
  output int                 fail_count,
  output int                 pending_count
);

  logic signed [31:0] bp_x [64];
  logic signed [31:0] bp_y [64];
  logic [6:0]         size_reg;
  logic signed [31:0] expected_y [$];

  function automatic logic signed [31:0] interp_y(input logic signed [31:0] qx);
    int n, lo, hi, mid;
    longint x0, y0, x1, y1, dx, dy, den, sum;
    logic neg;
    logic [127:0] prod, quo;
    n = (size_reg > 7'd64) ? 64 : int'(size_reg);
    if (n == 0) return 32'sd0;
    if (n == 1) return bp_y[0];
    if (qx <= bp_x[0]) return bp_y[0];
    if (qx >= bp_x[n-1]) return bp_y[n-1];
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (qx < bp_x[mid]) hi = mid;
      else lo = mid;
    end
    x0 = bp_x[lo];
    y0 = bp_y[lo];
    x1 = bp_x[lo+1];
    y1 = bp_y[lo+1];
    if (x1 == x0) return bp_y[lo];
    dx = longint'(qx) - x0;
    dy = y1 - y0;
    den = x1 - x0;
    neg = ((dx < 0) != (dy < 0)) != (den < 0);
    if (dx == 0 || dy == 0) neg = 1'b0;
    prod = 128'(dx < 0 ? -dx : dx);
    prod = prod * 128'(dy < 0 ? -dy : dy);
    quo = prod / 128'(den < 0 ? -den : den);
    // quotient saturates at 2^40
    if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
    sum = neg ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      size_reg <= '0;
      fail_count <= 0;
      pending_count <= 0;
      expected_y.delete();
    end else begin
      if (cfg_we) size_reg <= cfg_wdata;
      if (in_valid && in_ready) begin
        if (in_command == tli_pkg::CMD_LOAD) begin
          bp_x[in_entry_index] = in_entry_x;
          bp_y[in_entry_index] = in_entry_y;
        end else begin
          expected_y.push_back(interp_y(in_query_x));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_y.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result y=%0d at %0t", out_result_y, $realtime);
          fail_count <= fail_count + 1;
        end else begin
          if (out_result_y !== expected_y[0]) begin
            if (fail_count < 10)
              $display("result_y mismatch: expected %0d actual %0d at %0t",
                       expected_y[0], out_result_y, $realtime);
            fail_count <= fail_count + 1;
          end
          void'(expected_y.pop_front());
        end
      end
      pending_count <= expected_y.size();
    end
  end

endmodule

// File: test/testbench.sv
// Top of the interpolator testbench: clock, reset, stimulus and verdict.
// Depends on tli_pkg, table_linear_interpolator_core and interp_check.
`timescale 1ns / 100ps

module testbench;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [6:0]         cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_command = tli_pkg::CMD_QUERY;
  logic [5:0]         in_entry_index = '0;
  logic signed [31:0] in_entry_x = '0;
  logic signed [31:0] in_entry_y = '0;
  logic signed [31:0] in_query_x = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_result_y;

  int fail_count, pending_count;
  int items_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int phase_no = 0;
  int active_n;
  bit calm = 1'b0;    // when set, no random gaps or stalls are drawn

  // top's own view of the table, used only to aim queries
  logic signed [31:0] tx [64];
  logic signed [31:0] ty [64];

  always #1 clk = ~clk;

  table_linear_interpolator_core dut (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_ready, .in_command, .in_entry_index,
    .in_entry_x, .in_entry_y, .in_query_x,
    .out_valid, .out_ready, .out_result_y
  );

  interp_check chk (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_ready, .in_command, .in_entry_index,
    .in_entry_x, .in_entry_y, .in_query_x,
    .out_valid, .out_ready, .out_result_y,
    .fail_count, .pending_count
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: after each taken result, drop ready for a random stall (none drawn while calm)
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      stall_left <= calm ? 0 : $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Call right after a posedge. Valid stays up across back-to-back items;
  // it only drops when a gap is drawn.
  task automatic send_item(input logic cmd, input logic [5:0] idx,
                           input logic signed [31:0] ex, input logic signed [31:0] ey,
                           input logic signed [31:0] qx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_entry_index <= idx;
    in_entry_x <= ex;
    in_entry_y <= ey;
    in_query_x <= qx;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (cmd == tli_pkg::CMD_LOAD) begin
      tx[idx] = ex;
      ty[idx] = ey;
    end
  endtask

  task automatic load_entry(input logic [5:0] idx, input logic signed [31:0] ex,
                            input logic signed [31:0] ey);
    send_item(tli_pkg::CMD_LOAD, idx, ex, ey, $urandom);
  endtask

  task automatic query(input logic signed [31:0] qx);
    send_item(tli_pkg::CMD_QUERY, 6'($urandom), $urandom, $urandom, qx);
  endtask

  // Wait for every result, let loads in flight finish, then write table_size.
  task automatic set_size(input logic [6:0] n);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_n = (n > 7'd64) ? 64 : int'(n);
  endtask

  // Fill all 64 slots: mostly ascending x at a random scale, sometimes noise.
  task automatic load_table();
    longint maxstep, start, acc, span;
    int unsigned sel;
    bit noisy;
    noisy = ($urandom_range(0, 4) == 0);
    sel = $urandom_range(0, 3);
    case (sel)
      0: maxstep = 1;
      1: maxstep = 16;
      2: maxstep = 65536;
      default: maxstep = 64'd1 << 26;
    endcase
    span = (64'd1 << 32) - 1 - 63 * maxstep;
    start = -64'sd2147483648 + longint'($urandom_range(0, int'(span)));
    acc = start;
    for (int i = 0; i < 64; i++) begin
      if (noisy) load_entry(6'(i), $urandom, $urandom);
      else load_entry(6'(i), acc[31:0], $urandom);
      // occasional zero step makes equal breakpoints
      acc += ($urandom_range(0, 15) == 0) ? 0 : longint'($urandom_range(1, int'(maxstep)));
    end
  endtask

  task automatic random_query();
    int unsigned pick;
    int seg;
    longint lo, d;
    pick = $urandom_range(0, 99);
    if (active_n >= 2 && pick < 60) begin
      seg = $urandom_range(0, active_n - 2);
      lo = tx[seg];
      d = longint'(tx[seg+1]) - lo;
      if (d > 0) query(32'(lo + longint'($urandom_range(0, int'(d)))));
      else query(tx[seg]);
    end else if (active_n >= 1 && pick < 75) begin
      query(tx[$urandom_range(0, active_n - 1)]);
    end else begin
      query($urandom);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table after reset returns zero
    query(32'sh8000_0000);
    query(32'sh7fff_ffff);

    // extreme breakpoints, equal pair at x=0, last slot written
    load_entry(6'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    load_entry(6'd1, 32'sh0000_0000, 32'sh8000_0000);
    load_entry(6'd2, 32'sh0000_0000, 32'sh0000_0005);
    load_entry(6'd3, 32'sh7fff_ffff, 32'sh7fff_ffff);
    load_entry(6'd63, 32'sh7fff_ffff, 32'sh8000_0000);

    set_size(7'd1);
    query(32'sh0000_0000);
    set_size(7'd4);
    query(32'sh8000_0000);     // clamp to first y
    query(32'sh7fff_ffff);     // clamp to last y
    query(32'shffff_ffff);     // full-span segment, saturating sum
    query(32'sh0000_0000);     // on the equal pair
    query(32'sh0000_0001);
    query(32'sh4000_0000);
    query(32'sh8000_0001);

    // random phases; each rewrites the whole table before querying
    while (items_sent < 1800) begin
      calm = ($urandom_range(0, 3) == 0);
      load_table();
      case (phase_no % 6)
        0: set_size(7'd64);
        1: set_size(7'd127);     // oversized acts as full depth
        2: set_size(7'd1);
        3: set_size(7'd2);
        4: set_size(7'd0);
        default: set_size(7'($urandom_range(2, 63)));
      endcase
      repeat (100) begin
        if ($urandom_range(0, 99) < 12) load_entry(6'($urandom), $urandom, $urandom);
        else random_query();
      end
      phase_no++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/tli_pkg.sv
hdl/tli_ram.sv
hdl/tli_divider.sv
hdl/table_linear_interpolator_core.sv
test/interp_check.sv
test/testbench.sv
